// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
		else $error("implication check failed");

// Equality of two expressions at every rising edge outside reset
`define ASSERT_EQUAL(lbl, clk, rstn, lhs, rhs) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) ((lhs) == (rhs))) \
		else $error("equality check failed");

`endif

// ===== rtl/spef_pkg.sv =====
// Types, constants and step functions for the effective precession field core
package spef_pkg;

	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 32;
	localparam int RCP_LAT = SQ_STEPS + DIV_STEPS;

	localparam logic [31:0] ANOMALY_RST = 32'd311297;

	typedef enum logic [3:0] {
		CFG_ANOMALY   = 4'd0,
		CFG_KEEP_MAG  = 4'd1,
		CFG_KEEP_LONG = 4'd2,
		CFG_KEEP_MOT  = 4'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] beta_x;
		logic signed [31:0] beta_y;
		logic signed [31:0] beta_z;
		logic signed [31:0] magnetic_x;
		logic signed [31:0] magnetic_y;
		logic signed [31:0] magnetic_z;
		logic signed [31:0] electric_x;
		logic signed [31:0] electric_y;
		logic signed [31:0] electric_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] field_x;
		logic signed [31:0] field_y;
		logic signed [31:0] field_z;
		logic               speed_invalid;
		logic               saturated;
	} out_item_t;

	// Results of the root and reciprocal pipeline
	typedef struct packed {
		logic [31:0] s;
		logic [31:0] lq;
		logic [31:0] mq;
	} rcp_res_t;

	// Operands that ride alongside the root and reciprocal pipeline
	typedef struct packed {
		logic [2:0][31:0] mg;
		logic [2:0][33:0] cr;
		logic [2:0][35:0] r;
		logic             inv;
	} side_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sq_step_t;

	typedef struct packed {
		logic [33:0] rem;
		logic        qbit;
	} div_step_t;

	// One digit of the restoring square root
	function automatic sq_step_t sqrt_step(input logic [34:0] rem, input logic [31:0] root,
			input logic [1:0] pair);
		logic [34:0] t;
		logic [34:0] trial;
		sq_step_t res;
		t = {rem[32:0], pair};
		trial = {1'b0, root, 2'b01};
		if (t >= trial) begin
			res.rem = t - trial;
			res.root = {root[30:0], 1'b1};
		end else begin
			res.rem = t;
			res.root = {root[30:0], 1'b0};
		end
		return res;
	endfunction

	// One quotient bit of the restoring division
	function automatic div_step_t div_step(input logic [33:0] rem, input logic inbit,
			input logic [32:0] den);
		logic [33:0] t;
		div_step_t res;
		t = {rem[32:0], inbit};
		if (t >= {1'b0, den}) begin
			res.rem = t - {1'b0, den};
			res.qbit = 1'b1;
		end else begin
			res.rem = t;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

// ===== rtl/spin_precession_effective_field_core.sv =====
// Top level of the effective spin precession field core
// Usage:
//   Raise start with an operand set on operands; it is taken at every edge where
//   start is high, and busy stays low, so a new transaction may enter every cycle.
//   One result per transaction appears on result with done high for exactly one
//   cycle, in the order of acceptance. Throughput is one transaction per cycle.
//   The root and reciprocal pipeline has 32 root stages and 32 division stages,
//   one result bit per stage; it follows three input stages and precedes four
//   coefficient, product, sum and round stages.
//   The receiver cannot stall: every result must be taken in its done cycle.
//   Configuration: write cfg_data to register cfg_index with cfg_valid; cfg_ready is
//   always high. Index 0 is the anomaly, 1..3 enable the magnetic, longitudinal and
//   motional terms. Write only while no transaction is in flight.
//   Reset clears all valid bits, drops work in flight, and restores the anomaly to
//   the electron value with all three terms enabled.
//   A speed at or above light gives zero fields with speed_invalid set; clamped
//   components set saturated.
module spin_precession_effective_field_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  spef_pkg::in_item_t   operands,
	output logic                 done,
	output spef_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import spef_pkg::*;
	`include "assert_macros.svh"

	logic signed [31:0] anomaly_q;
	logic               keep_mag_q;
	logic               keep_long_q;
	logic               keep_mot_q;

	logic signed [31:0] bt_in [3];
	logic signed [31:0] mg_in [3];
	logic signed [31:0] el_in [3];

	// stage 1: products
	logic               v_s1;
	logic signed [63:0] sq_s1 [3];
	logic signed [63:0] bm_s1 [3];
	logic signed [63:0] be_s1 [3][3];
	logic signed [31:0] bt_s1 [3];
	logic signed [31:0] mg_s1 [3];

	// stage 2: sums
	logic               v_s2;
	logic [63:0]        rad_s2;
	logic               inv_s2;
	logic signed [34:0] dot_s2;
	logic signed [33:0] cr_s2 [3];
	logic signed [31:0] bt_s2 [3];
	logic signed [31:0] mg_s2 [3];
	logic [63:0]        b2;

	// stage 3: longitudinal projection
	logic               v_s3;
	logic [63:0]        rad_s3;
	side_t              side_s3;

	side_t              side_q [RCP_LAT];
	logic               side_v_q [RCP_LAT];

	logic               rcp_v;
	rcp_res_t           rcp;

	// stage 4: coefficients
	logic               v_s4;
	side_t              side_s4;
	logic signed [32:0] cm_s4;
	logic signed [32:0] cmo_s4;
	logic signed [64:0] kp_s4;

	// stage 5: term products
	logic               v_s5;
	logic               inv_s5;
	logic signed [64:0] pm_s5 [3];
	logic signed [69:0] pl_s5 [3];
	logic signed [66:0] pc_s5 [3];
	logic signed [33:0] k_s4;

	// stage 6: sums
	logic               v_s6;
	logic               inv_s6;
	logic signed [71:0] acc_s6 [3];

	// stage 7: round and clamp
	logic               v_s7;
	out_item_t          res_s7;
	logic signed [55:0] rq [3];
	logic signed [31:0] fld [3];
	logic [2:0]         clip;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anomaly_q <= ANOMALY_RST;
			keep_mag_q <= 1'b1;
			keep_long_q <= 1'b1;
			keep_mot_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ANOMALY:   anomaly_q <= cfg_data;
				CFG_KEEP_MAG:  keep_mag_q <= cfg_data[0];
				CFG_KEEP_LONG: keep_long_q <= cfg_data[0];
				CFG_KEEP_MOT:  keep_mot_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign bt_in[0] = operands.beta_x;
	assign bt_in[1] = operands.beta_y;
	assign bt_in[2] = operands.beta_z;
	assign mg_in[0] = operands.magnetic_x;
	assign mg_in[1] = operands.magnetic_y;
	assign mg_in[2] = operands.magnetic_z;
	assign el_in[0] = operands.electric_x;
	assign el_in[1] = operands.electric_y;
	assign el_in[2] = operands.electric_z;

	assign b2 = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < RCP_LAT; k++) side_v_q[k] <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			side_v_q[0] <= v_s3;
			for (int k = 1; k < RCP_LAT; k++) side_v_q[k] <= side_v_q[k-1];
			v_s4 <= rcp_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= bt_in[i] * bt_in[i];
			bm_s1[i] <= bt_in[i] * mg_in[i];
			for (int j = 0; j < 3; j++) be_s1[i][j] <= bt_in[i] * el_in[j];
			bt_s1[i] <= bt_in[i];
			mg_s1[i] <= mg_in[i];
		end

		inv_s2 <= b2[63:62] != 2'b00;
		rad_s2 <= 64'h4000000000000000 - b2;
		dot_s2 <= 35'(bm_s1[0] >>> 31) + 35'(bm_s1[1] >>> 31) + 35'(bm_s1[2] >>> 31);
		cr_s2[0] <= 34'(be_s1[1][2] >>> 31) - 34'(be_s1[2][1] >>> 31);
		cr_s2[1] <= 34'(be_s1[2][0] >>> 31) - 34'(be_s1[0][2] >>> 31);
		cr_s2[2] <= 34'(be_s1[0][1] >>> 31) - 34'(be_s1[1][0] >>> 31);
		for (int i = 0; i < 3; i++) begin
			bt_s2[i] <= bt_s1[i];
			mg_s2[i] <= mg_s1[i];
		end

		rad_s3 <= rad_s2;
		side_s3.inv <= inv_s2;
		for (int i = 0; i < 3; i++) begin
			side_s3.mg[i] <= mg_s2[i];
			side_s3.cr[i] <= cr_s2[i];
			side_s3.r[i] <= 36'((68'(bt_s2[i]) * 68'(dot_s2)) >>> 31);
		end

		side_q[0] <= side_s3;
		for (int k = 1; k < RCP_LAT; k++) side_q[k] <= side_q[k-1];

		side_s4 <= side_q[RCP_LAT-1];
		cm_s4 <= 33'(anomaly_q) + $signed({4'b0000, rcp.s[31:3]});
		cmo_s4 <= 33'(anomaly_q) + $signed({4'b0000, rcp.mq[31:3]});
		kp_s4 <= anomaly_q * $signed({1'b0, rcp.lq});

		inv_s5 <= side_s4.inv;
		for (int i = 0; i < 3; i++) begin
			pm_s5[i] <= $signed(side_s4.mg[i]) * cm_s4;
			pl_s5[i] <= $signed(side_s4.r[i]) * k_s4;
			pc_s5[i] <= $signed(side_s4.cr[i]) * cmo_s4;
		end

		inv_s6 <= inv_s5;
		for (int i = 0; i < 3; i++) begin
			acc_s6[i] <= (keep_mag_q ? 72'(pm_s5[i] >>> 12) : 72'sd0)
				- (keep_long_q ? 72'(pl_s5[i] >>> 12) : 72'sd0)
				- (keep_mot_q ? 72'(pc_s5[i] >>> 12) : 72'sd0);
		end

		res_s7.field_x <= inv_s6 ? 32'sd0 : fld[0];
		res_s7.field_y <= inv_s6 ? 32'sd0 : fld[1];
		res_s7.field_z <= inv_s6 ? 32'sd0 : fld[2];
		res_s7.speed_invalid <= inv_s6;
		res_s7.saturated <= !inv_s6 && (clip != 3'b000);
	end

	assign k_s4 = 34'(kp_s4 >>> 31);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rq[i] = 56'((acc_s6[i] + 72'sd32768) >>> 16);
			clip[i] = 1'b0;
			fld[i] = rq[i][31:0];
			if (rq[i] > 56'sd2147483647) begin
				fld[i] = 32'sh7fffffff;
				clip[i] = 1'b1;
			end else if (rq[i] < -56'sd2147483648) begin
				fld[i] = 32'sh80000000;
				clip[i] = 1'b1;
			end
		end
	end

	spef_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.out_valid (rcp_v),
		.res       (rcp)
	);

	assign done = v_s7;
	assign result = res_s7;

	`ASSERT_EQUAL(a_rcp_align, clk, arst_n, rcp_v, side_v_q[RCP_LAT-1])
	`ASSERT_IMPLIES(a_inv_zero, clk, arst_n, done && result.speed_invalid,
		result.field_x == 32'sd0 && result.field_y == 32'sd0 && result.field_z == 32'sd0)
	`ASSERT_IMPLIES(a_inv_nosat, clk, arst_n, done, !(result.speed_invalid && result.saturated))

endmodule

// ===== rtl/spef_recip.sv =====
// Pipelined square root of 1 - beta^2 followed by the two divisions by one plus the root
module spef_recip (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [63:0]         rad,
	output logic                out_valid,
	output spef_pkg::rcp_res_t  res
);
	import spef_pkg::*;

	logic [34:0] sq_rem_s  [SQ_STEPS];
	logic [31:0] sq_root_s [SQ_STEPS];
	logic [63:0] sq_d_s    [SQ_STEPS];
	logic        sq_v_s    [SQ_STEPS];

	logic [33:0] dv_r1_s  [DIV_STEPS];
	logic [33:0] dv_r2_s  [DIV_STEPS];
	logic [31:0] dv_q1_s  [DIV_STEPS];
	logic [31:0] dv_q2_s  [DIV_STEPS];
	logic [31:0] dv_n2_s  [DIV_STEPS];
	logic [32:0] dv_den_s [DIV_STEPS];
	logic [31:0] dv_s_s   [DIV_STEPS];
	logic        dv_v_s   [DIV_STEPS];

	sq_step_t  sq_nxt [SQ_STEPS];
	div_step_t d1_nxt [DIV_STEPS];
	div_step_t d2_nxt [DIV_STEPS];

	logic [31:0] root_fin;
	logic [32:0] den_init;

	assign root_fin = sq_root_s[SQ_STEPS-1];
	assign den_init = {1'b0, root_fin} + 33'h080000000;

	always_comb begin
		sq_nxt[0] = sqrt_step(35'd0, 32'd0, rad[63:62]);
		for (int k = 1; k < SQ_STEPS; k++) begin
			sq_nxt[k] = sqrt_step(sq_rem_s[k-1], sq_root_s[k-1], sq_d_s[k-1][63:62]);
		end
		d1_nxt[0] = div_step(34'h040000000, 1'b0, den_init);
		d2_nxt[0] = div_step({3'b0, root_fin[31:1]}, root_fin[0], den_init);
		for (int k = 1; k < DIV_STEPS; k++) begin
			d1_nxt[k] = div_step(dv_r1_s[k-1], 1'b0, dv_den_s[k-1]);
			d2_nxt[k] = div_step(dv_r2_s[k-1], dv_n2_s[k-1][31], dv_den_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STEPS; k++) sq_v_s[k] <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) dv_v_s[k] <= 1'b0;
		end else begin
			sq_v_s[0] <= in_valid;
			for (int k = 1; k < SQ_STEPS; k++) sq_v_s[k] <= sq_v_s[k-1];
			dv_v_s[0] <= sq_v_s[SQ_STEPS-1];
			for (int k = 1; k < DIV_STEPS; k++) dv_v_s[k] <= dv_v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0] <= sq_nxt[0].rem;
		sq_root_s[0] <= sq_nxt[0].root;
		sq_d_s[0] <= {rad[61:0], 2'b00};
		for (int k = 1; k < SQ_STEPS; k++) begin
			sq_rem_s[k] <= sq_nxt[k].rem;
			sq_root_s[k] <= sq_nxt[k].root;
			sq_d_s[k] <= {sq_d_s[k-1][61:0], 2'b00};
		end
		dv_r1_s[0] <= d1_nxt[0].rem;
		dv_r2_s[0] <= d2_nxt[0].rem;
		dv_q1_s[0] <= {31'd0, d1_nxt[0].qbit};
		dv_q2_s[0] <= {31'd0, d2_nxt[0].qbit};
		dv_n2_s[0] <= 32'd0;
		dv_den_s[0] <= den_init;
		dv_s_s[0] <= root_fin;
		for (int k = 1; k < DIV_STEPS; k++) begin
			dv_r1_s[k] <= d1_nxt[k].rem;
			dv_r2_s[k] <= d2_nxt[k].rem;
			dv_q1_s[k] <= {dv_q1_s[k-1][30:0], d1_nxt[k].qbit};
			dv_q2_s[k] <= {dv_q2_s[k-1][30:0], d2_nxt[k].qbit};
			dv_n2_s[k] <= {dv_n2_s[k-1][30:0], 1'b0};
			dv_den_s[k] <= dv_den_s[k-1];
			dv_s_s[k] <= dv_s_s[k-1];
		end
	end

	assign out_valid = dv_v_s[DIV_STEPS-1];
	assign res.s = dv_s_s[DIV_STEPS-1];
	assign res.lq = dv_q1_s[DIV_STEPS-1];
	assign res.mq = dv_q2_s[DIV_STEPS-1];

endmodule
